// File: sv/segment_ball_interval_macros.svh
// Assertion helpers used by segment_ball_interval.
`ifndef SEGMENT_BALL_INTERVAL_MACROS_SVH
`define SEGMENT_BALL_INTERVAL_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SBI_AST_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SBI_AST_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: sv/sbi_pkg.sv
package sbi_pkg;

    localparam int COORD_W    = 32;
    localparam int T_FRAC     = 16;
    localparam int IDX_W      = 16;
    localparam int RAD_W      = 31;
    localparam int TOL_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam int DIF_W  = COORD_W + 1;
    localparam int PRD_W  = 2 * DIF_W;
    localparam int A_W    = PRD_W;
    localparam int B_W    = PRD_W + 1;
    localparam int HALF_W = (A_W + 1) / 2;
    localparam int PPH_W  = 2 * HALF_W;
    localparam int PP_W   = 2 * A_W;
    localparam int DISC_W = PP_W + 2;
    localparam int ROOT_W = DISC_W / 2;
    localparam int NB_W   = B_W + 1;
    localparam int N_W    = NB_W + 2;
    localparam int T_W    = T_FRAC + 1;

    localparam int IN_FLD_W    = 9 * COORD_W + IDX_W;
    localparam int IN_TDATA_W  = ((IN_FLD_W + 7) / 8) * 8;
    localparam int OUT_FLD_W   = 2 * T_W + IDX_W;
    localparam int OUT_TDATA_W = ((OUT_FLD_W + 7) / 8) * 8;
    localparam int USER_W      = 1;

    localparam logic [T_W-1:0] T_ONE = {1'b1, {T_FRAC{1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RADIUS = 2'd0,
        CFG_TOL    = 2'd1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        TM_ZERO = 2'd0,
        TM_FULL = 2'd1,
        TM_DIV  = 2'd2
    } t_tmode;

    typedef struct packed {
        logic [A_W-1:0]   a;
        logic [NB_W-1:0]  nb;
        logic [IDX_W-1:0] idx;
        logic             degen;
        logic             dneg;
        logic             tang;
    } t_sq_meta;

    typedef struct packed {
        logic             hit;
        logic [T_W-1:0]   tb;
        logic [T_W-1:0]   te;
        logic [IDX_W-1:0] idx;
    } t_result;

endpackage

// File: sv/sbi_sqrt.sv
module sbi_sqrt (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [sbi_pkg::DISC_W-1:0]   i_rad,
    input  sbi_pkg::t_sq_meta            i_meta,
    output logic                         o_valid,
    output logic [sbi_pkg::ROOT_W-1:0]   o_root,
    output sbi_pkg::t_sq_meta            o_meta
);
    import sbi_pkg::*;

    localparam int STEPS = ROOT_W;

    logic [DISC_W-1:0] r_x   [0:STEPS];
    logic [DISC_W-1:0] r_res [0:STEPS];
    t_sq_meta          r_meta [0:STEPS];
    logic [STEPS:0]    r_vld;

    logic [DISC_W-1:0] w_bit [0:STEPS-1];
    logic [DISC_W-1:0] w_try [0:STEPS-1];
    logic [DISC_W-1:0] n_x   [0:STEPS-1];
    logic [DISC_W-1:0] n_res [0:STEPS-1];

    // one root bit per stage
    always_comb begin
        for (int g = 0; g < STEPS; g++) begin
            w_bit[g] = DISC_W'(1) << (DISC_W - 2 - 2 * g);
            w_try[g] = r_res[g] + w_bit[g];
            if (r_x[g] >= w_try[g]) begin
                n_x[g]   = r_x[g] - w_try[g];
                n_res[g] = (r_res[g] >> 1) + w_bit[g];
            end else begin
                n_x[g]   = r_x[g];
                n_res[g] = r_res[g] >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= i_rad;
            r_res[0]  <= '0;
            r_meta[0] <= i_meta;
            for (int g = 0; g < STEPS; g++) begin
                r_x[g+1]    <= n_x[g];
                r_res[g+1]  <= n_res[g];
                r_meta[g+1] <= r_meta[g];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[STEPS-1:0], i_valid};
        end
    end

    assign o_valid = r_vld[STEPS];
    assign o_root  = r_res[STEPS][ROOT_W-1:0];
    assign o_meta  = r_meta[STEPS];

endmodule

// File: sv/sbi_div.sv
module sbi_div (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  sbi_pkg::t_tmode           i_mode,
    input  logic [sbi_pkg::A_W-1:0]   i_num,
    input  logic [sbi_pkg::A_W-1:0]   i_den,
    output logic [sbi_pkg::T_W-1:0]   o_t
);
    import sbi_pkg::*;

    logic [A_W-1:0]    r_rem  [0:T_FRAC];
    logic [A_W-1:0]    r_den  [0:T_FRAC];
    logic [T_FRAC-1:0] r_q    [0:T_FRAC];
    t_tmode            r_mode [0:T_FRAC];

    logic [A_W:0]      w_rem2 [0:T_FRAC-1];
    logic [A_W:0]      w_dif  [0:T_FRAC-1];
    logic              w_ge   [0:T_FRAC-1];
    logic [A_W-1:0]    n_rem  [0:T_FRAC-1];
    logic [T_FRAC-1:0] n_q    [0:T_FRAC-1];

    // restoring division, one quotient bit per stage
    always_comb begin
        for (int g = 0; g < T_FRAC; g++) begin
            w_rem2[g] = {r_rem[g], 1'b0};
            w_dif[g]  = w_rem2[g] - {1'b0, r_den[g]};
            w_ge[g]   = (w_rem2[g] >= {1'b0, r_den[g]});
            n_rem[g]  = w_ge[g] ? w_dif[g][A_W-1:0] : w_rem2[g][A_W-1:0];
            n_q[g]    = {r_q[g][T_FRAC-2:0], w_ge[g]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= i_num;
            r_den[0]  <= i_den;
            r_q[0]    <= '0;
            r_mode[0] <= i_mode;
            for (int g = 0; g < T_FRAC; g++) begin
                r_rem[g+1]  <= n_rem[g];
                r_den[g+1]  <= r_den[g];
                r_q[g+1]    <= n_q[g];
                r_mode[g+1] <= r_mode[g];
            end
        end
    end

    always_comb begin
        unique case (r_mode[T_FRAC])
            TM_FULL: o_t = T_ONE;
            TM_DIV:  o_t = {1'b0, r_q[T_FRAC]};
            default: o_t = '0;
        endcase
    end

endmodule

// File: sv/segment_ball_interval.sv
// Throughput: one transaction per cycle while the skid buffer is empty;
// the 67-stage square root and the two 16-stage dividers are fully pipelined,
// one bit per stage.
// A one-entry skid buffer lets input continue while one result waits downstream.
// Reset (i_rst_n low, synchronous) empties the pipeline; radius = 0, tolerance = 1.
`include "segment_ball_interval_macros.svh"

module segment_ball_interval (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // center_x/y/z, start_x/y/z, end_x/y/z, cell_index
    input  logic [sbi_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // t_begin, t_end, index_out, zero pad
    output logic [sbi_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    // hit
    output logic [sbi_pkg::USER_W-1:0]         o_m_axis_tuser,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [sbi_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [sbi_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import sbi_pkg::*;

    logic [RAD_W-1:0] r_radius;
    logic [TOL_W-1:0] r_tol;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= '0;
            r_tol    <= TOL_W'(1);
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_RADIUS: r_radius <= i_cfg_data[RAD_W-1:0];
                CFG_TOL:    r_tol    <= i_cfg_data[TOL_W-1:0];
                default: ;
            endcase
        end
    end

    logic r_skd_valid;
    logic pipe_en;
    assign pipe_en         = !r_skd_valid;
    assign o_s_axis_tready = pipe_en;

    logic [COORD_W-1:0] w_cen [0:2];
    logic [COORD_W-1:0] w_st  [0:2];
    logic [COORD_W-1:0] w_en  [0:2];
    logic [IDX_W-1:0]   w_idx;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_cen[k] = i_s_axis_tdata[k * COORD_W +: COORD_W];
            w_st[k]  = i_s_axis_tdata[(3 + k) * COORD_W +: COORD_W];
            w_en[k]  = i_s_axis_tdata[(6 + k) * COORD_W +: COORD_W];
        end
        w_idx = i_s_axis_tdata[9 * COORD_W +: IDX_W];
    end

    // stage 1: direction and offset
    logic [DIF_W-1:0] r_s1_u [0:2];
    logic [DIF_W-1:0] r_s1_w [0:2];
    logic [IDX_W-1:0] r_s1_idx;
    // stage 2: products
    logic [PRD_W-1:0]   r_s2_uu [0:2];
    logic [PRD_W-1:0]   r_s2_uw [0:2];
    logic [PRD_W-1:0]   r_s2_ww [0:2];
    logic [2*RAD_W-1:0] r_s2_rr;
    logic [IDX_W-1:0]   r_s2_idx;
    // stage 3: a, b, c
    logic [A_W-1:0]   r_s3_a;
    logic [B_W-1:0]   r_s3_b;
    logic [B_W-1:0]   r_s3_c;
    logic [IDX_W-1:0] r_s3_idx;
    // stage 4: magnitudes
    logic [A_W-1:0]   r_s4_a;
    logic [A_W-1:0]   r_s4_bm;
    logic [A_W-1:0]   r_s4_cm;
    logic             r_s4_cneg;
    logic             r_s4_azero;
    logic [NB_W-1:0]  r_s4_nb;
    logic [IDX_W-1:0] r_s4_idx;
    // stage 5: partial products
    logic [PPH_W-1:0] r_s5_bhh, r_s5_bhl, r_s5_bll;
    logic [PPH_W-1:0] r_s5_ahh, r_s5_ahl, r_s5_alh, r_s5_all;
    logic [A_W-1:0]   r_s5_a;
    logic             r_s5_cneg;
    logic             r_s5_azero;
    logic [NB_W-1:0]  r_s5_nb;
    logic [IDX_W-1:0] r_s5_idx;
    // stage 6: b*b and a*|c|
    logic [PP_W-1:0]  r_s6_bb;
    logic [PP_W-1:0]  r_s6_ac;
    logic [A_W-1:0]   r_s6_a;
    logic             r_s6_cneg;
    logic             r_s6_azero;
    logic [NB_W-1:0]  r_s6_nb;
    logic [IDX_W-1:0] r_s6_idx;
    // stage 7: discriminant
    logic [DISC_W-1:0] r_s7_disc;
    logic [A_W-1:0]    r_s7_a;
    logic              r_s7_azero;
    logic [NB_W-1:0]   r_s7_nb;
    logic [IDX_W-1:0]  r_s7_idx;

    logic [7:1] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (pipe_en) begin
            r_vld <= {r_vld[6:1], i_s_axis_tvalid};
        end
    end

    logic [A_W-1:0]    w_s4_bm, w_s4_cm;
    logic [B_W-1:0]    w_s3_negb, w_s3_negc;
    logic [HALF_W-1:0] w_bh, w_bl, w_ah, w_al, w_ch, w_cl;

    always_comb begin
        w_s3_negb = B_W'(0) - r_s3_b;
        w_s3_negc = B_W'(0) - r_s3_c;
        w_s4_bm   = r_s3_b[B_W-1] ? w_s3_negb[A_W-1:0] : r_s3_b[A_W-1:0];
        w_s4_cm   = r_s3_c[B_W-1] ? w_s3_negc[A_W-1:0] : r_s3_c[A_W-1:0];
        w_bh = HALF_W'(r_s4_bm[A_W-1:HALF_W]);
        w_bl = r_s4_bm[HALF_W-1:0];
        w_ah = HALF_W'(r_s4_a[A_W-1:HALF_W]);
        w_al = r_s4_a[HALF_W-1:0];
        w_ch = HALF_W'(r_s4_cm[A_W-1:HALF_W]);
        w_cl = r_s4_cm[HALF_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            for (int k = 0; k < 3; k++) begin
                r_s1_u[k] <= {w_en[k][COORD_W-1], w_en[k]} - {w_st[k][COORD_W-1], w_st[k]};
                r_s1_w[k] <= {w_st[k][COORD_W-1], w_st[k]} - {w_cen[k][COORD_W-1], w_cen[k]};
                r_s2_uu[k] <= $signed(r_s1_u[k]) * $signed(r_s1_u[k]);
                r_s2_uw[k] <= $signed(r_s1_u[k]) * $signed(r_s1_w[k]);
                r_s2_ww[k] <= $signed(r_s1_w[k]) * $signed(r_s1_w[k]);
            end
            r_s1_idx <= w_idx;
            r_s2_rr  <= (2*RAD_W)'(r_radius) * (2*RAD_W)'(r_radius);
            r_s2_idx <= r_s1_idx;

            r_s3_a <= r_s2_uu[0] + r_s2_uu[1] + r_s2_uu[2];
            r_s3_b <= {r_s2_uw[0][PRD_W-1], r_s2_uw[0]} + {r_s2_uw[1][PRD_W-1], r_s2_uw[1]}
                    + {r_s2_uw[2][PRD_W-1], r_s2_uw[2]};
            r_s3_c <= {1'b0, r_s2_ww[0]} + {1'b0, r_s2_ww[1]} + {1'b0, r_s2_ww[2]}
                    - B_W'(r_s2_rr);
            r_s3_idx <= r_s2_idx;

            r_s4_a     <= r_s3_a;
            r_s4_bm    <= w_s4_bm;
            r_s4_cm    <= w_s4_cm;
            r_s4_cneg  <= r_s3_c[B_W-1];
            r_s4_azero <= (r_s3_a == '0);
            r_s4_nb    <= NB_W'(0) - {r_s3_b[B_W-1], r_s3_b};
            r_s4_idx   <= r_s3_idx;

            r_s5_bhh   <= PPH_W'(w_bh) * PPH_W'(w_bh);
            r_s5_bhl   <= PPH_W'(w_bh) * PPH_W'(w_bl);
            r_s5_bll   <= PPH_W'(w_bl) * PPH_W'(w_bl);
            r_s5_ahh   <= PPH_W'(w_ah) * PPH_W'(w_ch);
            r_s5_ahl   <= PPH_W'(w_ah) * PPH_W'(w_cl);
            r_s5_alh   <= PPH_W'(w_al) * PPH_W'(w_ch);
            r_s5_all   <= PPH_W'(w_al) * PPH_W'(w_cl);
            r_s5_a     <= r_s4_a;
            r_s5_cneg  <= r_s4_cneg;
            r_s5_azero <= r_s4_azero;
            r_s5_nb    <= r_s4_nb;
            r_s5_idx   <= r_s4_idx;

            r_s6_bb <= (PP_W'(r_s5_bhh) << (2 * HALF_W)) + (PP_W'(r_s5_bhl) << (HALF_W + 1))
                     + PP_W'(r_s5_bll);
            r_s6_ac <= (PP_W'(r_s5_ahh) << (2 * HALF_W))
                     + ((PP_W'(r_s5_ahl) + PP_W'(r_s5_alh)) << HALF_W) + PP_W'(r_s5_all);
            r_s6_a     <= r_s5_a;
            r_s6_cneg  <= r_s5_cneg;
            r_s6_azero <= r_s5_azero;
            r_s6_nb    <= r_s5_nb;
            r_s6_idx   <= r_s5_idx;

            r_s7_disc  <= r_s6_cneg ? ({2'b00, r_s6_bb} + {2'b00, r_s6_ac})
                                    : ({2'b00, r_s6_bb} - {2'b00, r_s6_ac});
            r_s7_a     <= r_s6_a;
            r_s7_azero <= r_s6_azero;
            r_s7_nb    <= r_s6_nb;
            r_s7_idx   <= r_s6_idx;
        end
    end

    t_sq_meta          w_sq_in;
    logic [DISC_W-1:0] w_sq_rad;
    logic              w_sq_vld;
    logic [ROOT_W-1:0] w_root;
    t_sq_meta          w_sq_out;

    always_comb begin
        w_sq_in.a     = r_s7_a;
        w_sq_in.nb    = r_s7_nb;
        w_sq_in.idx   = r_s7_idx;
        w_sq_in.degen = r_s7_azero;
        w_sq_in.dneg  = r_s7_disc[DISC_W-1];
        w_sq_in.tang  = !r_s7_disc[DISC_W-1] && (r_s7_disc < DISC_W'(r_tol));
        w_sq_rad      = r_s7_disc[DISC_W-1] ? '0 : r_s7_disc;
    end

    sbi_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (r_vld[7]),
        .i_rad   (w_sq_rad),
        .i_meta  (w_sq_in),
        .o_valid (w_sq_vld),
        .o_root  (w_root),
        .o_meta  (w_sq_out)
    );

    function automatic t_tmode f_mode(logic [N_W-1:0] n, logic [N_W-1:0] ax);
        t_tmode m;
        if (n[N_W-1]) begin
            m = TM_ZERO;
        end else if (n >= ax) begin
            m = TM_FULL;
        end else begin
            m = TM_DIV;
        end
        return m;
    endfunction

    logic [N_W-1:0] w_nx, w_sx, w_ax, w_n1, w_n2;
    logic           w_hit, w_below, w_beyond;
    t_tmode         w_mb, w_me;
    logic [A_W-1:0] w_numb, w_nume;

    always_comb begin
        w_nx     = {{(N_W-NB_W){w_sq_out.nb[NB_W-1]}}, w_sq_out.nb};
        w_sx     = N_W'(w_root);
        w_ax     = N_W'(w_sq_out.a);
        w_n1     = w_nx + w_sx;
        w_n2     = w_nx - w_sx;
        w_below  = w_n1[N_W-1] && w_n2[N_W-1];
        w_beyond = !w_n1[N_W-1] && (w_n1 > w_ax) && !w_n2[N_W-1] && (w_n2 > w_ax);
        w_numb   = w_n2[A_W-1:0];
        w_nume   = w_n1[A_W-1:0];
        priority if (w_sq_out.degen) begin
            w_hit = 1'b1;
            w_mb  = TM_ZERO;
            w_me  = TM_FULL;
        end else if (w_sq_out.dneg) begin
            w_hit = 1'b0;
            w_mb  = TM_ZERO;
            w_me  = TM_ZERO;
        end else if (w_sq_out.tang) begin
            w_hit  = !w_nx[N_W-1] && !(w_nx > w_ax);
            w_mb   = f_mode(w_nx, w_ax);
            w_me   = w_mb;
            w_numb = w_nx[A_W-1:0];
            w_nume = w_nx[A_W-1:0];
        end else begin
            w_hit = !w_below && !w_beyond;
            w_mb  = f_mode(w_n2, w_ax);
            w_me  = f_mode(w_n1, w_ax);
        end
        if (!w_hit) begin
            w_mb = TM_ZERO;
            w_me = TM_ZERO;
        end
    end

    t_tmode           r_r1_mb, r_r1_me;
    logic [A_W-1:0]   r_r1_numb, r_r1_nume, r_r1_a;
    logic             r_r1_hit;
    logic [IDX_W-1:0] r_r1_idx;
    logic             r_r1_vld;

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_r1_mb   <= w_mb;
            r_r1_me   <= w_me;
            r_r1_numb <= w_numb;
            r_r1_nume <= w_nume;
            r_r1_a    <= w_sq_out.a;
            r_r1_hit  <= w_hit;
            r_r1_idx  <= w_sq_out.idx;
        end
    end

    logic [T_FRAC:0]  r_dl_vld;
    logic             r_dl_hit [0:T_FRAC];
    logic [IDX_W-1:0] r_dl_idx [0:T_FRAC];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r1_vld <= 1'b0;
            r_dl_vld <= '0;
        end else if (pipe_en) begin
            r_r1_vld <= w_sq_vld;
            r_dl_vld <= {r_dl_vld[T_FRAC-1:0], r_r1_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_dl_hit[0] <= r_r1_hit;
            r_dl_idx[0] <= r_r1_idx;
            for (int g = 0; g < T_FRAC; g++) begin
                r_dl_hit[g+1] <= r_dl_hit[g];
                r_dl_idx[g+1] <= r_dl_idx[g];
            end
        end
    end

    logic [T_W-1:0] w_tb, w_te;

    sbi_div u_div_begin (
        .i_clk  (i_clk),
        .i_en   (pipe_en),
        .i_mode (r_r1_mb),
        .i_num  (r_r1_numb),
        .i_den  (r_r1_a),
        .o_t    (w_tb)
    );

    sbi_div u_div_end (
        .i_clk  (i_clk),
        .i_en   (pipe_en),
        .i_mode (r_r1_me),
        .i_num  (r_r1_nume),
        .i_den  (r_r1_a),
        .o_t    (w_te)
    );

    t_result w_res;
    logic    w_incoming;
    t_result r_out, r_skd;
    logic    r_out_valid;

    always_comb begin
        w_res.hit  = r_dl_hit[T_FRAC];
        w_res.tb   = w_tb;
        w_res.te   = w_te;
        w_res.idx  = r_dl_idx[T_FRAC];
        w_incoming = pipe_en && r_dl_vld[T_FRAC];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skd_valid <= 1'b0;
        end else begin
            priority if (r_skd_valid) begin
                if (!r_out_valid || i_m_axis_tready) begin
                    r_out_valid <= 1'b1;
                    r_skd_valid <= 1'b0;
                end
            end else if (w_incoming) begin
                if (!r_out_valid || i_m_axis_tready) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skd_valid <= 1'b1;
                end
            end else begin
                if (i_m_axis_tready) begin
                    r_out_valid <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (r_skd_valid) begin
            if (!r_out_valid || i_m_axis_tready) begin
                r_out <= r_skd;
            end
        end else begin
            if (w_incoming) begin
                if (!r_out_valid || i_m_axis_tready) begin
                    r_out <= w_res;
                end else begin
                    r_skd <= w_res;
                end
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_TDATA_W'({r_out.idx, r_out.te, r_out.tb});
    assign o_m_axis_tuser  = r_out.hit;

    `SBI_AST_IMP(a_skd_needs_out, r_skd_valid, r_out_valid)
    `SBI_AST_IMP(a_miss_zero, r_out_valid && !r_out.hit, r_out.tb == '0 && r_out.te == '0)
    `SBI_AST_IMP(a_interval_order, r_out_valid && r_out.hit, r_out.tb <= r_out.te && r_out.te <= T_ONE)
    `SBI_AST_NXT(a_skd_fill, w_incoming && r_out_valid && !i_m_axis_tready, r_skd_valid && r_out_valid)

endmodule

// File: tb/segment_ball_interval_checker.sv
`timescale 1ns / 100ps

module segment_ball_interval_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_valid,
    input  logic                            i_s_ready,
    input  logic [sbi_pkg::IN_TDATA_W-1:0]  i_s_data,
    input  logic                            i_m_valid,
    input  logic                            i_m_ready,
    input  logic [sbi_pkg::OUT_TDATA_W-1:0] i_m_data,
    input  logic [sbi_pkg::USER_W-1:0]      i_m_user,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [sbi_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [sbi_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending
);
    import sbi_pkg::*;

    typedef logic signed [191:0] t_wide;

    logic [RAD_W-1:0] radius_q = '0;
    logic [TOL_W-1:0] tol_q    = 1;
    t_result          interval_q[$];
    int               fail_q   = 0;

    assign o_fail_count = fail_q;
    assign o_pending    = interval_q.size();

    function automatic logic [191:0] floor_sqrt(logic [191:0] x);
        logic [191:0] root;
        logic [191:0] cand;
        root = '0;
        for (int k = 95; k >= 0; k--) begin
            cand = root | (192'd1 << k);
            if (cand * cand <= x) root = cand;
        end
        return root;
    endfunction

    function automatic logic [T_W-1:0] ratio_to_t(t_wide n, t_wide a);
        logic [191:0] num;
        if (n < 0) return '0;
        if (n >= a) return T_ONE;
        num = n <<< T_FRAC;
        return T_W'(num / a);
    endfunction

    function automatic t_result predict_interval(logic [IN_TDATA_W-1:0] d,
                                                 logic [RAD_W-1:0] rad,
                                                 logic [TOL_W-1:0] tol);
        t_wide   u, v, cen, st, en, a, b, c, r, disc, nb, s, n1, n2, tolw;
        t_result res;
        a = '0;
        b = '0;
        c = '0;
        for (int k = 0; k < 3; k++) begin
            cen = $signed(d[k*COORD_W +: COORD_W]);
            st  = $signed(d[(3+k)*COORD_W +: COORD_W]);
            en  = $signed(d[(6+k)*COORD_W +: COORD_W]);
            u = en - st;
            v = st - cen;
            a = a + u * u;
            b = b + u * v;
            c = c + v * v;
        end
        r    = {161'd0, rad};
        tolw = {160'd0, tol};
        c    = c - r * r;
        res  = '0;
        res.idx = d[9*COORD_W +: IDX_W];
        if (a == 0) begin
            res.hit = 1'b1;
            res.te  = T_ONE;
        end else begin
            disc = b * b - a * c;
            nb   = -b;
            if (disc >= 0) begin
                if (disc < tolw) begin
                    if (nb >= 0 && nb <= a) begin
                        res.hit = 1'b1;
                        res.tb  = ratio_to_t(nb, a);
                        res.te  = res.tb;
                    end
                end else begin
                    s  = floor_sqrt(disc);
                    n1 = nb + s;
                    n2 = nb - s;
                    if (!((n1 < 0 && n2 < 0) || (n1 > a && n2 > a))) begin
                        res.hit = 1'b1;
                        res.tb  = ratio_to_t(n2, a);
                        res.te  = ratio_to_t(n1, a);
                    end
                end
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_result got, want;
        if (!i_rst_n) begin
            radius_q <= '0;
            tol_q    <= 1;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_RADIUS) radius_q <= i_cfg_data[RAD_W-1:0];
                else if (i_cfg_index == CFG_TOL) tol_q <= i_cfg_data[TOL_W-1:0];
            end
            if (i_m_valid && i_m_ready) begin
                got.hit = i_m_user[0];
                got.tb  = i_m_data[0 +: T_W];
                got.te  = i_m_data[T_W +: T_W];
                got.idx = i_m_data[2*T_W +: IDX_W];
                if (interval_q.size() == 0) begin
                    $display("%0t: unexpected result hit=%0d tb=%0d te=%0d idx=%0d",
                             $time, got.hit, got.tb, got.te, got.idx);
                    fail_q++;
                end else begin
                    want = interval_q.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch exp hit=%0d tb=%0d te=%0d idx=%0d",
                                 $time, want.hit, want.tb, want.te, want.idx);
                        $display("%0t:          act hit=%0d tb=%0d te=%0d idx=%0d",
                                 $time, got.hit, got.tb, got.te, got.idx);
                        fail_q++;
                    end
                end
            end
            if (i_s_valid && i_s_ready)
                interval_q.push_back(predict_interval(i_s_data, radius_q, tol_q));
        end
    end

endmodule

// File: tb/tb_segment_ball_interval.sv
`timescale 1ns / 100ps

module tb_segment_ball_interval;
    import sbi_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 150;

    logic                   i_clk   = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [IN_TDATA_W-1:0]  s_data  = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_data;
    logic [USER_W-1:0]      m_user;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    int                     fail_count;
    int                     pending;
    int                     items_sent = 0;
    int                     burst_left = 0;
    int                     idle_cycles = 0;
    int                     hold_cnt = 0;
    bit                     hold_done = 1'b0;
    int                     ready_pct = 100;
    int                     cycle_cnt = 0;

    always #5 i_clk = ~i_clk;

    segment_ball_interval dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    segment_ball_interval_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_valid    (s_valid),
        .i_s_ready    (s_ready),
        .i_s_data     (s_data),
        .i_m_valid    (m_valid),
        .i_m_ready    (m_ready),
        .i_m_data     (m_data),
        .i_m_user     (m_user),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // receiver: varying stall density, one long hold-off mid-run
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt % 300 == 0) begin
            case ($urandom_range(0, 3))
                0: ready_pct = 100;
                1: ready_pct = 75;
                2: ready_pct = 40;
                default: ready_pct = 10;
            endcase
        end
        if (!hold_done && items_sent >= 700) begin
            hold_cnt  = 400;
            hold_done = 1'b1;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) < ready_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("segment_ball_interval regression: fail");
            $finish;
        end
    end

    function automatic logic [IN_TDATA_W-1:0] pack_query(int cx, int cy, int cz,
                                                         int sx, int sy, int sz,
                                                         int ex, int ey, int ez,
                                                         logic [IDX_W-1:0] idx);
        logic [IN_TDATA_W-1:0] d;
        d = '0;
        d[0*COORD_W +: COORD_W] = cx;
        d[1*COORD_W +: COORD_W] = cy;
        d[2*COORD_W +: COORD_W] = cz;
        d[3*COORD_W +: COORD_W] = sx;
        d[4*COORD_W +: COORD_W] = sy;
        d[5*COORD_W +: COORD_W] = sz;
        d[6*COORD_W +: COORD_W] = ex;
        d[7*COORD_W +: COORD_W] = ey;
        d[8*COORD_W +: COORD_W] = ez;
        d[9*COORD_W +: IDX_W]   = idx;
        return d;
    endfunction

    function automatic int jitter(int scale);
        return int'($urandom_range(0, 2 << scale)) - (1 << scale);
    endfunction

    function automatic logic [IN_TDATA_W-1:0] random_query();
        logic [IN_TDATA_W-1:0] d;
        int base[3];
        int p[9];
        int scale;
        int mode;
        mode  = $urandom_range(0, 9);
        scale = $urandom_range(2, 22);
        for (int k = 0; k < 3; k++) base[k] = $urandom;
        for (int k = 0; k < 9; k++) p[k] = base[k % 3] + jitter(scale);
        case (mode)
            0, 1: for (int k = 0; k < 9; k++) p[k] = $urandom;
            2: for (int k = 0; k < 3; k++) p[6 + k] = p[3 + k];
            3: for (int k = 0; k < 3; k++) p[k] = p[3 + k] + ((p[6 + k] - p[3 + k]) >>> 1);
            default: ;
        endcase
        d = pack_query(p[0], p[1], p[2], p[3], p[4], p[5], p[6], p[7], p[8],
                       IDX_W'($urandom));
        return d;
    endfunction

    task automatic send_query(logic [IN_TDATA_W-1:0] d);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0 && s_valid) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data  <= d;
        do @(posedge i_clk); while (!s_ready);
        items_sent++;
    endtask

    task automatic drain_queries();
        if (s_valid) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        logic [CFG_DATA_W-1:0] rad_set[6];
        logic [CFG_DATA_W-1:0] tol_set[6];
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_reg(CFG_RADIUS, 32'd2560);
        write_reg(CFG_TOL, 32'd1);
        send_query(pack_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 16'h0000));
        send_query(pack_query(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                              32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                              32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 16'hffff));
        send_query(pack_query(32'h80000000, 32'h80000000, 32'h80000000,
                              32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                              32'h80000000, 32'h80000000, 32'h80000000, 16'h8000));
        send_query(pack_query(32'h80000000, 32'h80000000, 32'h80000000,
                              32'h80000000, 32'h80000000, 32'h80000000,
                              32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 16'h0001));
        send_query(pack_query(0, 0, 0, 900000, 0, 0, 900000, 0, 0, 16'd7));
        send_query(pack_query(0, 0, 0, -5000, 0, 0, 5000, 0, 0, 16'd1));
        send_query(pack_query(0, 0, 0, 0, 0, 0, 10000, 0, 0, 16'd2));
        send_query(pack_query(0, 0, 0, 3000, 0, 0, 8000, 0, 0, 16'd3));
        send_query(pack_query(0, 0, 0, -8000, 0, 0, -3000, 0, 0, 16'd4));
        send_query(pack_query(0, 0, 0, -5000, 5000, 0, 5000, 5000, 0, 16'd5));
        send_query(pack_query(0, 0, 0, -5000, 2560, 0, 5000, 2560, 0, 16'd6));
        send_query(pack_query(0, 0, 0, -5000, 2561, 0, 5000, 2561, 0, 16'd8));
        send_query(pack_query(0, 0, 0, -100, 0, 0, 100, 0, 0, 16'd9));
        send_query(pack_query(0, 0, 0, 0, -5000, -5000, 0, 5000, 5000, 16'd10));
        send_query(pack_query(0, 0, 0, 100, 2560, 0, 5000, 2560, 0, 16'd11));
        send_query(pack_query(0, 0, 0, 0, 0, -1, 0, 0, 1, 16'd12));
        send_query(pack_query(10, 20, 30, 10, 20, 0, 10, 20, 0, 16'd13));
        drain_queries();

        rad_set = '{32'd0, 32'h7fffffff, 32'hffffffff, 32'd0, 32'd0, 32'd0};
        tol_set = '{32'd0, 32'hffffffff, 32'd1, 32'd0, 32'd0, 32'd0};
        for (int k = 3; k < 6; k++) begin
            rad_set[k] = $urandom >> $urandom_range(1, 31);
            tol_set[k] = $urandom >> $urandom_range(0, 32);
        end
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(CFG_RADIUS, rad_set[ph]);
            write_reg(CFG_TOL, tol_set[ph]);
            if (ph == 2) begin
                write_reg(CFG_UNUSED, $urandom);
                write_reg(CFG_SPARE, $urandom);
            end
            repeat (215) send_query(random_query());
            drain_queries();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("segment_ball_interval regression: pass");
        end else begin
            $display("segment_ball_interval regression: fail");
        end
        $finish;
    end

endmodule
